>>> hw/rtl/calorimeter_readout_bank_unpacker_defines.svh
// Assertion macros used by the bank unpacker queue.
// Depends on nothing; the assertion bodies are left out when SYNTH is defined.
`ifndef CALORIMETER_READOUT_BANK_UNPACKER_DEFINES_SVH
`define CALORIMETER_READOUT_BANK_UNPACKER_DEFINES_SVH
`ifndef SYNTH
// Checked property, muted while reset is high.
`define CRBU_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Checked property that also holds during reset.
`define CRBU_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define CRBU_ASSERT(lbl, ck, rs, prop, msg)
`define CRBU_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

>>> hw/rtl/crbu_pkg.sv
// Types, constants and helper functions of the bank unpacker.
// Depends on nothing; the top level, front end, queue and parser use it by scoped names.
package crbu_pkg;

  localparam int CHAN_PER_CARD = 32;
  localparam int PAT_IDX_W     = 5;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_PLAIN  = 2'd1;
  localparam logic [1:0] FMT_PACKED = 2'd2;
  localparam logic [1:0] FMT_TAGGED = 2'd3;

  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_SKIP   = 1'b1;

  typedef enum logic [2:0] {
    PH_START, PH_PLAIN, PH_HDR, PH_SKIP, PH_PAT, PH_DATA2, PH_DATA3, PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {BK_IDLE, BK_BODY, BK_HALF, BK_TAIL} bk_state_t;

  typedef enum logic [1:0] {
    KIND_ADC   = 2'd0,
    KIND_CARD  = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] format_version;
    logic       skip_first_word;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
    logic        last;
    logic [8:0]  card;
    logic [6:0]  count;
    logic [5:0]  skip;
    logic [2:0]  flags;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [8:0]         card;
    logic [2:0]         flags;
    logic [5:0]         channel;
    logic [15:0]        cell_id;
    logic signed [15:0] adc;
    logic               last;
  } result_t;

  // Phases in which a bank end means the card was cut short.
  function automatic logic in_card(phase_t p);
    return (p == PH_SKIP) || (p == PH_PAT) || (p == PH_DATA2) || (p == PH_DATA3);
  endfunction

  function automatic phase_t body_phase(logic [1:0] fmt);
    phase_t p;
    case (fmt)
      FMT_PLAIN: p = PH_PLAIN;
      FMT_NONE:  p = PH_DISCARD;
      default:   p = PH_HDR;
    endcase
    return p;
  endfunction

  function automatic phase_t after_trigger(logic [1:0] fmt, logic [6:0] left);
    phase_t p;
    if (fmt == FMT_TAGGED) begin
      p = (left != 7'd0) ? PH_DATA3 : PH_HDR;
    end else begin
      p = PH_PAT;
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/crbu_in_if.sv
// Input channel of the bank unpacker: one raw bank word per transaction.
// Depends on nothing.
interface crbu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        first_word;
  logic        final_word;

  modport source (output valid, data_word, first_word, final_word, input ready);
  modport sink (input valid, data_word, first_word, final_word, output ready);
endinterface

>>> hw/rtl/crbu_out_if.sv
// Output channel of the bank unpacker: one decoded result per transaction.
// Depends on nothing.
interface crbu_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [8:0]         card_code;
  logic [2:0]         link_flags;
  logic [5:0]         channel;
  logic [15:0]        cell_id;
  logic signed [15:0] adc_value;
  logic               last_result;

  modport source (output valid, kind, card_code, link_flags, channel, cell_id,
                  adc_value, last_result, input ready);
  modport sink (input valid, kind, card_code, link_flags, channel, cell_id,
                adc_value, last_result, output ready);
endinterface

>>> hw/rtl/calorimeter_readout_bank_unpacker.sv
// Calorimeter readout bank unpacker, top level.
// Raw bank words arrive on the in channel, one 32-bit word per transaction,
// with first_word and final_word marking the bank limits. Decoded results
// leave on the out channel, one per transaction; last_result marks the final
// result that one input word produced, and words that produce nothing send
// nothing. The format registers are written through cfg_we/cfg_index/cfg_data
// while the block is idle, a rule for the user that the block does not enforce;
// they take effect at the next bank start, format_version also at a card header.
// A word passes through the queue and the parser's word register, and its first
// result is captured in the result register that drives out.valid.
// The parser loads each word, runs its body steps (with a half step more for a
// format 3 data word) and a bank-end step before it loads the next; a format 2
// data word emits one result per cycle while the receiver does not stall.
// A two-entry queue lets the front end keep taking words while the parser
// works; while no result is pending, the result register lets the parser
// step on though the receiver is not ready; a stalled receiver holds the parser.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// puts the parser back to expecting a bank header; format_version resets to
// the pattern-compressed format and skip_first_word to zero.
// Depends on crbu_pkg, crbu_in_if, crbu_out_if, crbu_front, crbu_fifo, crbu_back.
module calorimeter_readout_bank_unpacker (
  input  logic       clk,
  input  logic       rst,
  crbu_in_if.sink    in,
  crbu_out_if.source out,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);
  crbu_pkg::cfg_t   cfg;
  crbu_pkg::entry_t q_wdata;
  crbu_pkg::entry_t q_rdata;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  // Configuration registers; a write lands on the register its index names.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_version  <= crbu_pkg::FMT_PACKED;
      cfg.skip_first_word <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        crbu_pkg::CFG_FORMAT: cfg.format_version  <= cfg_data;
        crbu_pkg::CFG_SKIP:   cfg.skip_first_word <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: accepts words and pre-decodes header fields.
  crbu_front u_front (
    .in    (in),
    .full  (q_full),
    .push  (q_push),
    .entry (q_wdata)
  );

  // Queue that decouples acceptance from parsing.
  crbu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Parser and result register.
  crbu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .pop     (q_pop),
    .out     (out)
  );
endmodule

>>> hw/rtl/crbu_front.sv
// Front end: takes input transactions and pre-decodes card header fields.
// Depends on crbu_pkg and crbu_in_if.
module crbu_front (
  crbu_in_if.sink         in,
  input  logic            full,
  output logic            push,
  output crbu_pkg::entry_t entry
);
  logic [8:0] ctrl;

  assign in.ready = !full;
  assign push     = in.valid && !full;
  assign ctrl     = in.data_word[31:23];

  always_comb begin
    entry.word  = in.data_word;
    entry.first = in.first_word;
    entry.last  = in.final_word;
    entry.card  = in.data_word[22:14];
    entry.count = in.data_word[13:7];
    entry.skip  = 6'(({1'b0, in.data_word[6:0]} + 8'd3) >> 2);
    entry.flags = {ctrl[6], ctrl[5], ctrl[0]};
  end
endmodule

>>> hw/rtl/crbu_fifo.sv
// Short queue between the front end and the parser.
// Depends on crbu_pkg and the assertion macro header.
`include "calorimeter_readout_bank_unpacker_defines.svh"
module crbu_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crbu_pkg::entry_t wdata,
  input  logic             pop,
  output crbu_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);
  crbu_pkg::entry_t                  store [crbu_pkg::QDEPTH];
  logic [crbu_pkg::QPTR_W-1:0]       wr_ptr;
  logic [crbu_pkg::QPTR_W-1:0]       rd_ptr;
  logic [crbu_pkg::QCNT_W-1:0]       cnt;

  assign full  = (cnt == crbu_pkg::QCNT_W'(crbu_pkg::QDEPTH));
  assign empty = (cnt == '0);
  assign rdata = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `CRBU_ASSERT(a_cnt_bound, clk, rst, cnt <= crbu_pkg::QCNT_W'(crbu_pkg::QDEPTH), "queue overfilled")
  `CRBU_ASSERT(a_no_underflow, clk, rst, !(pop && empty), "pop from empty queue")
  `CRBU_ASSERT(a_fill, clk, rst, push && !pop |=> cnt == $past(cnt) + 1'b1, "queue count slipped")
endmodule

>>> hw/rtl/crbu_back.sv
// Parser: walks queued words through the bank format and emits results.
// Depends on crbu_pkg and crbu_out_if.
module crbu_back (
  input  logic             clk,
  input  logic             rst,
  input  crbu_pkg::cfg_t   cfg,
  input  logic             q_empty,
  input  crbu_pkg::entry_t q_data,
  output logic             pop,
  crbu_out_if.source       out
);
  crbu_pkg::bk_state_t st, st_next;
  crbu_pkg::phase_t    phase, phase_next;
  crbu_pkg::entry_t    cur, cur_next;
  logic [5:0]          skip_left, skip_left_next;
  logic [31:0]         pat, pat_next;
  logic [5:0]          ch, ch_next;
  logic [5:0]          pos, pos_next;
  logic [3:0]          bo, bo_next;
  logic [11:0]         pv, pv_next;
  logic [6:0]          vl, vl_next;
  logic [8:0]          card, card_next;
  logic                o_valid;
  crbu_pkg::result_t   o_res;
  crbu_pkg::result_t   res;
  logic                emit, body_done, go, load_drop;

  assign go  = !o_valid || out.ready;
  assign pop = (st == crbu_pkg::BK_IDLE) && !q_empty;
  assign load_drop = (q_data.first || (phase == crbu_pkg::PH_START)) && cfg.skip_first_word;

  // Sequencing of one word: load, body steps (none if dropped), bank-end step.
  always_comb begin
    st_next = st;
    case (st)
      crbu_pkg::BK_IDLE: begin
        if (!q_empty) begin
          st_next = load_drop ? crbu_pkg::BK_TAIL : crbu_pkg::BK_BODY;
        end
      end
      crbu_pkg::BK_BODY: begin
        if (go) begin
          if (phase == crbu_pkg::PH_DATA3) begin
            st_next = crbu_pkg::BK_HALF;
          end else if (body_done) begin
            st_next = crbu_pkg::BK_TAIL;
          end
        end
      end
      crbu_pkg::BK_HALF: begin
        if (go) begin
          st_next = crbu_pkg::BK_TAIL;
        end
      end
      crbu_pkg::BK_TAIL: begin
        if (go) begin
          st_next = crbu_pkg::BK_IDLE;
        end
      end
      default: st_next = crbu_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    logic [31:0]          sh;
    logic [11:0]          v12;
    logic [5:0]           ch_n;
    logic [5:0]           pos_n;
    logic [6:0]           vl_n;
    logic                 cont;
    crbu_pkg::phase_t     nph;
    phase_next     = phase;
    cur_next       = cur;
    skip_left_next = skip_left;
    pat_next       = pat;
    ch_next        = ch;
    pos_next       = pos;
    bo_next        = bo;
    pv_next        = pv;
    vl_next        = vl;
    card_next      = card;
    emit           = 1'b0;
    body_done      = 1'b0;
    res            = '0;
    res.card       = card;
    res.channel    = ch;
    sh             = cur.word >> pos;
    v12            = '0;
    ch_n           = ch;
    pos_n          = pos;
    vl_n           = vl;
    cont           = 1'b0;
    nph            = phase;
    case (st)
      crbu_pkg::BK_IDLE: begin
        if (!q_empty) begin
          cur_next = q_data;
          pos_next = '0;
          if (q_data.first || (phase == crbu_pkg::PH_START)) begin
            phase_next = crbu_pkg::body_phase(cfg.format_version);
            bo_next    = '0;
            pv_next    = '0;
          end
        end
      end
      crbu_pkg::BK_BODY: begin
        if (go) begin
          case (phase)
            crbu_pkg::PH_PLAIN: begin
              emit      = 1'b1;
              res.kind  = crbu_pkg::KIND_ADC;
              res.card  = '0;
              res.channel = '0;
              res.cell_id = cur.word[31:16];
              res.adc   = $signed(cur.word[15:0]);
              res.last  = 1'b1;
              body_done = 1'b1;
            end
            crbu_pkg::PH_HDR: begin
              nph = (cur.skip != 6'd0) ? crbu_pkg::PH_SKIP
                  : crbu_pkg::after_trigger(cfg.format_version, cur.count);
              card_next      = cur.card;
              vl_next        = cur.count;
              skip_left_next = cur.skip;
              bo_next        = '0;
              pv_next        = '0;
              phase_next     = nph;
              emit           = 1'b1;
              res.kind       = crbu_pkg::KIND_CARD;
              res.card       = cur.card;
              res.flags      = cur.flags;
              res.channel    = '0;
              res.last       = !(cur.last && crbu_pkg::in_card(nph));
              body_done      = 1'b1;
            end
            crbu_pkg::PH_SKIP: begin
              skip_left_next = skip_left - 6'(skip_left != 6'd0);
              if (skip_left_next == 6'd0) begin
                phase_next = crbu_pkg::after_trigger(cfg.format_version, vl);
              end
              body_done = 1'b1;
            end
            crbu_pkg::PH_PAT: begin
              pat_next   = cur.word;
              ch_next    = '0;
              bo_next    = '0;
              pv_next    = '0;
              phase_next = crbu_pkg::PH_DATA2;
              body_done  = 1'b1;
            end
            crbu_pkg::PH_DATA2: begin
              if (bo != 4'd0) begin
                // Second part of a 12-bit value that straddled the word boundary.
                v12     = pv | 12'(cur.word << bo);
                emit    = 1'b1;
                res.adc = $signed({4'b0, v12}) - 16'sd256;
                ch_n    = ch + 6'd1;
                pos_n   = 6'd12 - {2'b0, bo};
                bo_next = '0;
                pv_next = '0;
              end else if ((ch < 6'(crbu_pkg::CHAN_PER_CARD)) && (pos < 6'd32)) begin
                if (!pat[ch[crbu_pkg::PAT_IDX_W-1:0]]) begin
                  emit    = 1'b1;
                  res.adc = $signed({12'b0, sh[3:0]}) - 16'sd8;
                  ch_n    = ch + 6'd1;
                  pos_n   = pos + 6'd4;
                end else if (pos <= 6'd20) begin
                  emit    = 1'b1;
                  res.adc = $signed({4'b0, sh[11:0]}) - 16'sd256;
                  ch_n    = ch + 6'd1;
                  pos_n   = pos + 6'd12;
                end else begin
                  bo_next   = 4'(6'd32 - pos);
                  pv_next   = sh[11:0];
                  body_done = 1'b1;
                end
              end else begin
                if (ch >= 6'(crbu_pkg::CHAN_PER_CARD)) begin
                  phase_next = crbu_pkg::PH_HDR;
                end
                body_done = 1'b1;
              end
              if (emit) begin
                cont = (ch_n < 6'(crbu_pkg::CHAN_PER_CARD)) && (pos_n < 6'd32) &&
                       (pat[ch_n[crbu_pkg::PAT_IDX_W-1:0]] ? (pos_n <= 6'd20)
                                                            : (pos_n <= 6'd28));
                res.kind = crbu_pkg::KIND_ADC;
                res.last = !(cont || (cur.last && (ch_n < 6'(crbu_pkg::CHAN_PER_CARD))));
                ch_next  = ch_n;
                pos_next = pos_n;
              end
            end
            crbu_pkg::PH_DATA3: begin
              if (vl != 7'd0) begin
                vl_n        = vl - 7'd1;
                vl_next     = vl_n;
                emit        = 1'b1;
                res.kind    = crbu_pkg::KIND_ADC;
                res.channel = cur.word[15:10];
                res.adc     = $signed({6'b0, cur.word[9:0]});
                res.last    = (vl_n == 7'd0);
              end
            end
            default: body_done = 1'b1;
          endcase
        end
      end
      crbu_pkg::BK_HALF: begin
        if (go) begin
          if (vl != 7'd0) begin
            vl_n        = vl - 7'd1;
            emit        = 1'b1;
            res.kind    = crbu_pkg::KIND_ADC;
            res.channel = cur.word[31:26];
            res.adc     = $signed({6'b0, cur.word[25:16]});
            res.last    = !(cur.last && (vl_n != 7'd0));
          end
          vl_next = vl_n;
          if (vl_n == 7'd0) begin
            phase_next = crbu_pkg::PH_HDR;
          end
        end
      end
      crbu_pkg::BK_TAIL: begin
        if (go && cur.last) begin
          if (crbu_pkg::in_card(phase)) begin
            emit        = 1'b1;
            res.kind    = crbu_pkg::KIND_TRUNC;
            res.channel = '0;
            res.last    = 1'b1;
          end
          phase_next = crbu_pkg::PH_START;
          bo_next    = '0;
          pv_next    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= crbu_pkg::BK_IDLE;
      phase     <= crbu_pkg::PH_START;
      skip_left <= '0;
      pat       <= '0;
      ch        <= '0;
      pos       <= '0;
      bo        <= '0;
      pv        <= '0;
      vl        <= '0;
      card      <= '0;
      o_valid   <= 1'b0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      skip_left <= skip_left_next;
      pat       <= pat_next;
      ch        <= ch_next;
      pos       <= pos_next;
      bo        <= bo_next;
      pv        <= pv_next;
      vl        <= vl_next;
      card      <= card_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      o_res <= res;
    end
  end

  assign out.valid       = o_valid;
  assign out.kind        = o_res.kind;
  assign out.card_code   = o_res.card;
  assign out.link_flags  = o_res.flags;
  assign out.channel     = o_res.channel;
  assign out.cell_id     = o_res.cell_id;
  assign out.adc_value   = o_res.adc;
  assign out.last_result = o_res.last;
endmodule
